### rtl/fre_pkg.sv
// Shared types and constants for the four-register instruction execute block.
package fre_pkg;

	// Operation codes of a decoded instruction.
	typedef enum logic [3:0] {
		OP_MV  = 4'd0,
		OP_AD  = 4'd1,
		OP_SB  = 4'd2,
		OP_MU  = 4'd3,
		OP_IC  = 4'd4,
		OP_DC  = 4'd5,
		OP_JP  = 4'd6,
		OP_JC  = 4'd7,
		OP_JZ  = 4'd8,
		OP_JL  = 4'd9,
		OP_JM  = 4'd10,
		OP_NP  = 4'd11,
		OP_EX  = 4'd12,
		OP_LD  = 4'd13,
		OP_XT  = 4'd14,
		OP_UNK = 4'd15
	} op_t;

	// Source operand kinds.
	typedef enum logic [1:0] {
		SRC_REG = 2'd0,
		SRC_IMM = 2'd1,
		SRC_MEM = 2'd2,
		SRC_BAD = 2'd3
	} src_t;

	// Register file indexes.
	localparam logic [1:0] GPR_C = 2'd2;
	localparam logic [1:0] GPR_D = 2'd3;

	// Counter step of an unrecognized opcode.
	localparam logic [16:0] UNKNOWN_STEP = 17'd3;

	// Configuration register byte addresses.
	localparam logic [1:0] ADDR_PROGRAM_LENGTH = 2'd0;

	// One decoded instruction request.
	typedef struct packed {
		logic [3:0]         req_type;
		logic [1:0]         dest_select;
		logic [1:0]         source_kind;
		logic [1:0]         source_select;
		logic [14:0]        immediate_value;
		logic signed [15:0] memory_value;
		logic [15:0]        jump_target;
		logic [7:0]         instr_length;
	} req_t;

	// One execution result.
	typedef struct packed {
		logic signed [15:0] reg_a;
		logic signed [15:0] reg_b;
		logic signed [15:0] reg_c;
		logic signed [15:0] reg_d;
		logic [15:0]        next_counter;
		logic               bad_argument;
		logic               finished;
	} rsp_t;

	// Architectural state of the machine.
	typedef struct packed {
		logic [3:0][15:0] gpr;
		logic [15:0]      pc;
		logic             halted;
	} arch_t;

endpackage

### rtl/four_register_instruction_execute_top.sv
// Top level of the four-register instruction execute block.
// Result: written to the output register, or to the skid stage while the output is stalled.
// Throughput: one request per unstalled cycle; register file and counter update on accept.
// Backpressure: a two-entry output buffer; req_stall rises only when both entries are full.
// Reset: registers A-D, the counter, the halt flag and program_length clear to zero.
module four_register_instruction_execute_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  fre_pkg::req_t  req_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output fre_pkg::rsp_t  rsp_data,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [1:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import fre_pkg::*;

	arch_t       state_q;
	arch_t       state_nxt;
	rsp_t        exec_rsp;
	logic [15:0] program_length_q;
	logic        accept;
	logic        buf_full;

	assign accept    = req_valid && !req_stall;
	assign req_stall = buf_full;
	assign pready    = 1'b1;

	// Configuration register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			program_length_q <= 16'd0;
		end else if (psel && penable && pwrite && (paddr == ADDR_PROGRAM_LENGTH)) begin
			program_length_q <= pwdata[15:0];
		end
	end

	// Configuration register read.
	always_comb begin
		prdata = 32'd0;
		if (paddr == ADDR_PROGRAM_LENGTH) begin
			prdata = {16'd0, program_length_q};
		end
	end

	// Execute one instruction against the current state.
	fre_exec u_exec (
		.cur            (state_q),
		.req            (req_data),
		.program_length (program_length_q),
		.nxt            (state_nxt),
		.rsp            (exec_rsp)
	);

	// Architectural state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// Result buffering.
	fre_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (exec_rsp),
		.full      (buf_full),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	// Only reset clears the halt flag.
	assert property (@(posedge clk) disable iff (!arst_n) state_q.halted |=> state_q.halted)
		else $error("halt flag cleared without reset");

	// Once halted, the registers and counter no longer change.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.halted |=> ($stable(state_q.gpr) && $stable(state_q.pc)))
		else $error("state changed after halt");

endmodule

### rtl/fre_exec.sv
// Combinational execute stage: next architectural state and result of one instruction.
module fre_exec (
	input  fre_pkg::arch_t cur,
	input  fre_pkg::req_t  req,
	input  logic [15:0]    program_length,
	output fre_pkg::arch_t nxt,
	output fre_pkg::rsp_t  rsp
);
	import fre_pkg::*;

	logic [15:0] op_a;
	logic [15:0] op_b;
	logic [15:0] gpr_c;
	logic [15:0] alu;
	logic [16:0] next_pc;
	logic        stopped;
	logic        take;
	logic        bad;

	// Operand selection.
	always_comb begin
		op_a  = cur.gpr[req.dest_select];
		gpr_c = cur.gpr[GPR_C];
		case (src_t'(req.source_kind))
			SRC_REG: op_b = cur.gpr[req.source_select];
			SRC_IMM: op_b = {1'b0, req.immediate_value};
			default: op_b = req.memory_value;
		endcase
	end

	// Arithmetic unit: one adder, one subtractor, a 16-bit low-half multiply, else op_b.
	always_comb begin
		case (op_t'(req.req_type))
			OP_AD:   alu = op_a + op_b;
			OP_SB:   alu = op_a - op_b;
			OP_MU:   alu = op_a * op_b;
			default: alu = op_b;
		endcase
	end

	// Instruction effect on registers and counter.
	always_comb begin
		nxt     = cur;
		bad     = 1'b0;
		take    = 1'b0;
		next_pc = {1'b0, cur.pc} + {9'd0, req.instr_length};
		stopped = cur.halted || (cur.pc >= program_length);

		if (stopped) begin
			nxt.halted = 1'b1;
		end else begin
			case (op_t'(req.req_type))
				OP_MV, OP_AD, OP_SB, OP_MU: begin
					if (src_t'(req.source_kind) == SRC_BAD) begin
						bad = 1'b1;
					end else begin
						nxt.gpr[req.dest_select] = alu;
					end
				end
				OP_IC: nxt.gpr[req.dest_select] = op_a + 16'd1;
				OP_DC: nxt.gpr[req.dest_select] = op_a - 16'd1;
				OP_JP: take = 1'b1;
				OP_JC, OP_JM: take = (gpr_c != 16'd0) && !gpr_c[15];
				OP_JZ: take = (gpr_c == 16'd0);
				OP_JL: take = gpr_c[15];
				OP_EX: nxt.halted = 1'b1;
				OP_LD: nxt.gpr[GPR_D] = req.memory_value;
				OP_NP, OP_XT: ;
				default: next_pc = {1'b0, cur.pc} + UNKNOWN_STEP;
			endcase

			if (take) begin
				next_pc = {1'b0, req.jump_target};
			end
			// Reaching or passing the end of the program text ends execution.
			if (next_pc >= {1'b0, program_length}) begin
				nxt.halted = 1'b1;
			end
			nxt.pc = next_pc[15:0];
		end
	end

	// Result fields.
	always_comb begin
		rsp.reg_a        = nxt.gpr[0];
		rsp.reg_b        = nxt.gpr[1];
		rsp.reg_c        = nxt.gpr[2];
		rsp.reg_d        = nxt.gpr[3];
		rsp.next_counter = nxt.pc;
		rsp.bad_argument = bad;
		rsp.finished     = nxt.halted;
	end

endmodule

### rtl/fre_skid.sv
// Output register with a skid stage, so results can wait while new requests are taken.
module fre_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fre_pkg::rsp_t push_data,
	output logic          full,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output fre_pkg::rsp_t rsp_data
);
	import fre_pkg::*;

	logic out_valid_q;
	logic skid_valid_q;
	rsp_t out_q;
	rsp_t skid_q;
	logic pop;

	assign pop       = out_valid_q && !rsp_stall;
	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;
	assign full      = skid_valid_q;

	// Valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= skid_valid_q && push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= skid_valid_q ? skid_q : push_data;
			if (skid_valid_q && push) begin
				skid_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	// The skid stage only holds a result behind a waiting output register.
	assert property (@(posedge clk) disable iff (!arst_n) skid_valid_q |-> out_valid_q)
		else $error("skid stage valid without output register valid");

	// No request is pushed while the skid stage is occupied.
	assert property (@(posedge clk) disable iff (!arst_n) skid_valid_q |-> !push)
		else $error("push into a full skid buffer");

	// A result that is not taken stays in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rsp_stall) |=> (out_valid_q && $stable(out_q)))
		else $error("stalled result changed");

endmodule

### tb/tb.sv
// Self-checking testbench for the four-register instruction execute block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fre_pkg::*;

	localparam logic [1:0] GPR_A = 2'd0;
	localparam logic [1:0] GPR_B = 2'd1;
	localparam int DIRECTED_ROWS = 25;
	localparam int SETTLE_CYCLES = 4;
	localparam int LIMIT_CYCLES = 200000;
	localparam logic [15:0] FULL_LENGTH = 16'hffff;

	typedef struct {
		req_t q;
		bit   typed;
		rsp_t want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req_data = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Predicted machine state and the program length the block holds.
	arch_t       machine = '0;
	logic [15:0] prog_len = '0;
	rsp_t        pending_results[$];
	rsp_t        oldest;
	plan_row_t   plan [DIRECTED_ROWS];

	int    errors = 0;
	int    requests_sent = 0;
	int    results_seen = 0;
	int    bad_seen = 0;
	int    finished_seen = 0;
	int    cycles = 0;
	int    stall_left = 0;
	bit    idle_on = 1'b1;
	string ending_desc;

	always #2 clk = ~clk;

	four_register_instruction_execute_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Behavior of one instruction: new state and the result it reports.
	function automatic void run_instruction(input arch_t s, input req_t q,
			input logic [15:0] plen, output rsp_t r, output arch_t n);
		logic [16:0] step_to;
		logic [15:0] lhs;
		logic [15:0] rhs;
		logic        take;
		logic        bad;
		logic        c_pos;
		n = s;
		bad = 1'b0;
		take = 1'b0;
		c_pos = s.gpr[GPR_C] != 16'd0 && !s.gpr[GPR_C][15];
		step_to = {1'b0, s.pc} + 17'(q.instr_length);
		if (s.halted || s.pc >= plen) begin
			// Execution already over: nothing changes but the halt flag.
			n.halted = 1'b1;
		end else begin
			case (op_t'(q.req_type))
				OP_MV, OP_AD, OP_SB, OP_MU: begin
					if (src_t'(q.source_kind) == SRC_BAD) begin
						bad = 1'b1;
					end else begin
						lhs = s.gpr[q.dest_select];
						case (src_t'(q.source_kind))
							SRC_REG: rhs = s.gpr[q.source_select];
							SRC_IMM: rhs = {1'b0, q.immediate_value};
							default: rhs = q.memory_value;
						endcase
						case (op_t'(q.req_type))
							OP_MV:   n.gpr[q.dest_select] = rhs;
							OP_AD:   n.gpr[q.dest_select] = lhs + rhs;
							OP_SB:   n.gpr[q.dest_select] = lhs - rhs;
							default: n.gpr[q.dest_select] = lhs * rhs;
						endcase
					end
				end
				OP_IC: n.gpr[q.dest_select] = s.gpr[q.dest_select] + 16'd1;
				OP_DC: n.gpr[q.dest_select] = s.gpr[q.dest_select] - 16'd1;
				OP_JP: take = 1'b1;
				OP_JC, OP_JM: take = c_pos;
				OP_JZ: take = s.gpr[GPR_C] == 16'd0;
				OP_JL: take = s.gpr[GPR_C][15];
				OP_EX: n.halted = 1'b1;
				OP_LD: n.gpr[GPR_D] = q.memory_value;
				OP_NP, OP_XT: ;
				default: step_to = {1'b0, s.pc} + UNKNOWN_STEP;
			endcase
			if (take)
				step_to = {1'b0, q.jump_target};
			// The end test uses the counter before it wraps.
			if (step_to >= {1'b0, plen})
				n.halted = 1'b1;
			n.pc = step_to[15:0];
		end
		r.reg_a = n.gpr[GPR_A];
		r.reg_b = n.gpr[GPR_B];
		r.reg_c = n.gpr[GPR_C];
		r.reg_d = n.gpr[GPR_D];
		r.next_counter = n.pc;
		r.bad_argument = bad;
		r.finished = n.halted;
	endfunction

	function automatic req_t mk(input op_t op, input logic [1:0] dst, input src_t kind,
			input logic [1:0] sel, input logic [14:0] imm, input logic [15:0] mem,
			input logic [15:0] tgt, input logic [7:0] len);
		req_t q;
		q.req_type = op;
		q.dest_select = dst;
		q.source_kind = kind;
		q.source_select = sel;
		q.immediate_value = imm;
		q.memory_value = mem;
		q.jump_target = tgt;
		q.instr_length = len;
		return q;
	endfunction

	// Random instruction; exit is left out unless any_op is set.
	function automatic req_t rand_req(input bit any_op);
		req_t q;
		q.req_type = 4'($urandom_range(0, 15));
		if (!any_op && q.req_type == OP_EX)
			q.req_type = OP_NP;
		q.dest_select = 2'($urandom);
		q.source_kind = ($urandom_range(0, 7) == 0) ? 2'(SRC_BAD) : 2'($urandom_range(0, 2));
		q.source_select = 2'($urandom);
		q.immediate_value = 15'($urandom);
		q.memory_value = 16'($urandom);
		if ($urandom_range(0, 15) == 0)
			q.memory_value = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
		if ($urandom_range(0, 15) == 0)
			q.immediate_value = 15'h7fff;
		q.jump_target = (prog_len == 16'd0) ? 16'($urandom)
			: 16'($urandom_range(0, int'(prog_len) - 1));
		q.instr_length = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(1, 12));
		return q;
	endfunction

	// Random instruction that keeps the program running: one that would end it
	// turns into a jump back into the first half of the program.
	function automatic req_t running_req();
		req_t  q;
		rsp_t  r;
		arch_t n;
		q = rand_req(1'b0);
		run_instruction(machine, q, prog_len, r, n);
		if (n.halted) begin
			q.req_type = OP_JP;
			q.jump_target = 16'($urandom_range(0, int'(prog_len) / 2));
		end
		return q;
	endfunction

	// Hand one request to the block and record what it must answer.
	task automatic issue(input req_t q, input bit typed, input rsp_t want);
		rsp_t  r;
		arch_t n;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= q;
		do @(posedge clk); while (!(req_valid && !req_stall));
		run_instruction(machine, q, prog_len, r, n);
		machine = n;
		pending_results.push_back(typed ? want : r);
		requests_sent++;
	endtask

	// Stop sending and wait until the block has answered everything.
	task automatic settle();
		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register access; a read compares against value, a write stores it.
	task automatic reg_access(input bit wr, input logic [1:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wr ? value : 32'd0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (wr) begin
			if (addr == ADDR_PROGRAM_LENGTH)
				prog_len = value[15:0];
		end else if (prdata !== value) begin
			errors++;
			$display("%0t: register read expected %h, got %h", $time, value, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_field(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %h, got %h", $time, what, want, got);
		end
	endtask

	// Compare each result with the oldest prediction, then pick the next stall.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result expected none, got %h", $time, rsp_data);
			end else begin
				oldest = pending_results.pop_front();
				check_field("reg_a", oldest.reg_a, rsp_data.reg_a);
				check_field("reg_b", oldest.reg_b, rsp_data.reg_b);
				check_field("reg_c", oldest.reg_c, rsp_data.reg_c);
				check_field("reg_d", oldest.reg_d, rsp_data.reg_d);
				check_field("next_counter", oldest.next_counter, rsp_data.next_counter);
				check_field("bad_argument", 16'(oldest.bad_argument),
					16'(rsp_data.bad_argument));
				check_field("finished", 16'(oldest.finished), 16'(rsp_data.finished));
				if (oldest.bad_argument)
					bad_seen++;
				if (oldest.finished)
					finished_seen++;
			end
		end
		if (!idle_on) begin
			stall_left = 0;
			rsp_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 3);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Timed out after %0d cycles with %0d results pending.", cycles,
				pending_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int          mid_len;
		int          mode;
		logic [15:0] end_pc;

		// Directed rows; only those right after reset carry a typed answer.
		plan = '{
			'{mk(OP_MV, GPR_A, SRC_BAD, GPR_A, 15'd0, 16'h0000, 16'd0, 8'd7), 1'b1,
				{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd7, 1'b1, 1'b0}},
			'{mk(OP_MV, GPR_A, SRC_IMM, GPR_A, 15'h7fff, 16'h0000, 16'd0, 8'd1), 1'b1,
				{16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'd8, 1'b0, 1'b0}},
			'{mk(OP_MV, GPR_B, SRC_MEM, GPR_A, 15'd0, 16'h8000, 16'd0, 8'd255), 1'b1,
				{16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'd263, 1'b0, 1'b0}},
			'{mk(OP_AD, GPR_A, SRC_REG, GPR_B, 15'd0, 16'h0000, 16'd0, 8'd3), 1'b0, '0},
			'{mk(OP_SB, GPR_B, SRC_IMM, GPR_A, 15'd1, 16'h0000, 16'd0, 8'd4), 1'b0, '0},
			'{mk(OP_MU, GPR_A, SRC_MEM, GPR_A, 15'd0, 16'hffff, 16'd0, 8'd5), 1'b0, '0},
			'{mk(OP_MV, GPR_D, SRC_IMM, GPR_A, 15'd300, 16'h0000, 16'd0, 8'd2), 1'b0, '0},
			'{mk(OP_MU, GPR_D, SRC_REG, GPR_D, 15'd0, 16'h0000, 16'd0, 8'd2), 1'b0, '0},
			'{mk(OP_AD, GPR_C, SRC_BAD, GPR_A, 15'd9, 16'h0009, 16'd0, 8'd6), 1'b0, '0},
			'{mk(OP_MU, GPR_B, SRC_BAD, GPR_C, 15'd9, 16'h0009, 16'd0, 8'd2), 1'b0, '0},
			'{mk(OP_IC, GPR_A, SRC_REG, GPR_A, 15'd0, 16'h0000, 16'd0, 8'd1), 1'b0, '0},
			'{mk(OP_LD, GPR_A, SRC_REG, GPR_A, 15'd0, 16'h1234, 16'd0, 8'd4), 1'b0, '0},
			'{mk(OP_XT, GPR_B, SRC_MEM, GPR_A, 15'd0, 16'h4321, 16'd0, 8'd9), 1'b0, '0},
			'{mk(OP_NP, GPR_A, SRC_REG, GPR_A, 15'd0, 16'h0000, 16'd0, 8'd0), 1'b0, '0},
			'{mk(OP_UNK, GPR_C, SRC_IMM, GPR_A, 15'd5, 16'h0000, 16'd9, 8'd200), 1'b0, '0},
			'{mk(OP_JZ, GPR_A, SRC_REG, GPR_A, 15'd0, 16'h0000, 16'd40, 8'd2), 1'b0, '0},
			'{mk(OP_DC, GPR_C, SRC_REG, GPR_A, 15'd0, 16'h0000, 16'd0, 8'd1), 1'b0, '0},
			'{mk(OP_JL, GPR_A, SRC_REG, GPR_A, 15'd0, 16'h0000, 16'd1000, 8'd3), 1'b0, '0},
			'{mk(OP_JZ, GPR_A, SRC_REG, GPR_A, 15'd0, 16'h0000, 16'd5, 8'd2), 1'b0, '0},
			'{mk(OP_IC, GPR_C, SRC_REG, GPR_A, 15'd0, 16'h0000, 16'd0, 8'd1), 1'b0, '0},
			'{mk(OP_IC, GPR_C, SRC_REG, GPR_A, 15'd0, 16'h0000, 16'd0, 8'd1), 1'b0, '0},
			'{mk(OP_JC, GPR_A, SRC_REG, GPR_A, 15'd0, 16'h0000, 16'd60000, 8'd2), 1'b0, '0},
			'{mk(OP_JM, GPR_A, SRC_REG, GPR_A, 15'd0, 16'h0000, 16'd50, 8'd2), 1'b0, '0},
			'{mk(OP_JL, GPR_A, SRC_REG, GPR_A, 15'd0, 16'h0000, 16'd7, 8'd3), 1'b0, '0},
			'{mk(OP_JP, GPR_A, SRC_REG, GPR_A, 15'd0, 16'h0000, 16'd0, 8'd2), 1'b0, '0}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Program length reads zero after reset; open the whole address range.
		reg_access(1'b0, ADDR_PROGRAM_LENGTH, 32'd0);
		reg_access(1'b1, ADDR_PROGRAM_LENGTH, {16'd0, FULL_LENGTH});
		reg_access(1'b0, ADDR_PROGRAM_LENGTH, {16'd0, FULL_LENGTH});

		for (int i = 0; i < DIRECTED_ROWS; i++)
			issue(plan[i].q, plan[i].typed, plan[i].want);

		for (int i = 0; i < 650; i++) begin
			if (i % 64 == 0)
				idle_on = $urandom_range(0, 3) != 0;
			issue(running_req(), 1'b0, '0);
		end
		settle();

		// A new program length, capped at the full range, that still lies beyond the counter.
		mid_len = int'(machine.pc) + $urandom_range(300, 3000);
		if (mid_len > int'(FULL_LENGTH))
			mid_len = int'(FULL_LENGTH);
		reg_access(1'b1, ADDR_PROGRAM_LENGTH, 32'(mid_len));
		reg_access(1'b0, ADDR_PROGRAM_LENGTH, 32'(mid_len));
		for (int i = 0; i < 620; i++) begin
			if (i % 64 == 0)
				idle_on = $urandom_range(0, 3) != 0;
			issue(running_req(), 1'b0, '0);
		end
		settle();

		// Closing part without idling: end execution one of four ways.
		idle_on = 1'b0;
		reg_access(1'b1, ADDR_PROGRAM_LENGTH, {16'd0, FULL_LENGTH});
		mode = $urandom_range(0, 3);
		case (mode)
			0: begin
				ending_desc = "on an exit";
				issue(mk(OP_EX, GPR_A, SRC_REG, GPR_A, 15'd0, 16'h0000, 16'd0, 8'd4),
					1'b0, '0);
			end
			1: begin
				ending_desc = "on a jump to the program end";
				issue(mk(OP_JP, GPR_A, SRC_REG, GPR_A, 15'd0, 16'h0000, FULL_LENGTH, 8'd2),
					1'b0, '0);
			end
			2: begin
				ending_desc = "by cutting the program length to the counter";
				end_pc = machine.pc;
				reg_access(1'b1, ADDR_PROGRAM_LENGTH, {16'd0, end_pc});
			end
			default: begin
				ending_desc = "by running past the end with a wrapped counter";
				issue(mk(OP_JP, GPR_A, SRC_REG, GPR_A, 15'd0, 16'h0000, 16'd65400, 8'd2),
					1'b0, '0);
				issue(mk(OP_NP, GPR_A, SRC_REG, GPR_A, 15'd0, 16'h0000, 16'd0, 8'd255),
					1'b0, '0);
			end
		endcase
		for (int i = 0; i < 12; i++)
			issue(rand_req(1'b1), 1'b0, '0);
		settle();

		// A zero length does not bring a halted machine back.
		reg_access(1'b1, ADDR_PROGRAM_LENGTH, 32'd0);
		reg_access(1'b0, ADDR_PROGRAM_LENGTH, 32'd0);
		for (int i = 0; i < 6; i++)
			issue(rand_req(1'b1), 1'b0, '0);
		settle();

		$display("Covered %0d requests, %0d directed, over program lengths %0d, %0d and 0.",
			requests_sent, DIRECTED_ROWS, FULL_LENGTH, mid_len);
		$display("Checked %0d results, %0d with a bad argument, %0d finished; execution ended %s.",
			results_seen, bad_seen, finished_seen, ending_desc);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### files.f
rtl/fre_pkg.sv
rtl/fre_exec.sv
rtl/fre_skid.sv
rtl/four_register_instruction_execute_top.sv
tb/tb.sv
